[hdl/tcw_pkg.sv]
// Shared types and constants of the text console character writer.
// No dependencies; imported by the cursor unit and the top level.
package tcw_pkg;

  // Field widths of the ports
  localparam int CELL_W = 16;
  localparam int ATTR_W = 8;
  localparam int CODE_W = 8;
  localparam int POS_W  = 11;

  // Attribute byte after reset
  localparam logic [ATTR_W-1:0] RESET_COLOR = 8'd15;

  // Control codes understood by a put
  localparam logic [CODE_W-1:0] CH_BS      = 8'd8;
  localparam logic [CODE_W-1:0] CH_TAB     = 8'd9;
  localparam logic [CODE_W-1:0] CH_LF      = 8'd10;
  localparam logic [CODE_W-1:0] CH_FF      = 8'd12;
  localparam logic [CODE_W-1:0] CH_CR      = 8'd13;
  localparam logic [CODE_W-1:0] PRINT_LO   = 8'd32;
  localparam logic [CODE_W-1:0] PRINT_HI   = 8'd126;
  localparam int                TAB_STEP   = 8;

  // Cursor moves requested of the cursor unit
  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_STEP,
    CUR_BACK,
    CUR_TAB,
    CUR_LF,
    CUR_CR,
    CUR_HOME
  } cur_op_t;

endpackage

[hdl/text_console_char_writer.sv]
// Text console character writer: top level with sequencer and screen RAM.
// Depends on tcw_pkg, tcw_ram and tcw_cursor.
//
// Usage
//   Command channel: a word is taken at a rising edge with start high and
//   busy low. in_command 0 puts in_char_code, 1 reads cell in_cell_address.
//   Result channel: out_strobe is high for one cycle with out_cursor_pos and
//   out_cell_data; the receiver cannot stall, so it must take every word.
//   Config: cfg_we writes cfg_wdata as the attribute byte; write only idle.
// Timing
//   A read or an ordinary put keeps busy high through the S_READ or S_MARK
//   state after the accept; the result is strobed in the cycle after that,
//   when the next command may already be taken. The cost is the screen
//   RAM's single write port (character write, then cursor mark) and its
//   registered read.
//   Form feed sweeps the RAM one cell a cycle in S_CLEAR, then marks the
//   cursor in S_MARK, with busy high throughout; the result follows S_MARK.
// Reset
//   After reset the block blanks all COLS*ROWS cells in the reset colour
//   with busy high; cfg writes are still taken.
module text_console_char_writer #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_command,
  input  logic [tcw_pkg::CODE_W-1:0]  in_char_code,
  input  logic [tcw_pkg::POS_W-1:0]   in_cell_address,
  output logic                        out_strobe,
  output logic [tcw_pkg::POS_W-1:0]   out_cursor_pos,
  output logic [tcw_pkg::CELL_W-1:0]  out_cell_data,
  input  logic                        cfg_we,
  input  logic [tcw_pkg::ATTR_W-1:0]  cfg_wdata
);
  import tcw_pkg::*;

  localparam int CELLS = COLS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int PW    = (AW > POS_W) ? AW : POS_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MARK,
    S_READ,
    S_CLEAR
  } state_t;

  state_t                 state_r, state_nxt;
  logic [AW-1:0]          clr_addr_r;
  logic [ATTR_W-1:0]      clr_color_r;
  logic                   clr_ff_r;
  logic                   rd_ok_r;
  logic [ATTR_W-1:0]      color_r;
  logic                   out_strobe_r;
  logic [POS_W-1:0]       out_cursor_pos_r;
  logic [CELL_W-1:0]      out_cell_data_r;

  logic                   accept;
  logic                   printable;
  logic                   clr_last;
  logic [PW-1:0]          addr_ext;
  logic                   addr_ok;
  logic [PW-1:0]          cur_ext;
  logic [AW-1:0]          cursor;
  cur_op_t                cur_op;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [CELL_W-1:0]      ram_wdata;
  logic [CELL_W-1:0]      ram_rdata;

  assign accept    = start && !busy;
  assign printable = (in_char_code >= PRINT_LO) && (in_char_code <= PRINT_HI);
  assign clr_last  = (clr_addr_r == AW'(CELLS - 1));
  assign addr_ext  = PW'(in_cell_address);
  assign addr_ok   = addr_ext < PW'(CELLS);
  assign cur_ext   = PW'(cursor);

  // screen store
  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (addr_ext[AW-1:0]),
    .rdata (ram_rdata)
  );

  tcw_cursor #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_cursor (
    .clk    (clk),
    .rst_n  (rst_n),
    .op     (cur_op),
    .cursor (cursor)
  );

  // command decode, RAM write port and cursor moves
  always_comb begin
    state_nxt = state_r;
    cur_op    = CUR_HOLD;
    ram_we    = 1'b0;
    ram_waddr = cursor;
    ram_wdata = {color_r, CODE_W'(0)};
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_command) begin
            state_nxt = S_READ;
          end else begin
            state_nxt = S_MARK;
            unique case (in_char_code)
              CH_BS:  cur_op = CUR_BACK;
              CH_TAB: cur_op = CUR_TAB;
              CH_LF:  cur_op = CUR_LF;
              CH_CR:  cur_op = CUR_CR;
              CH_FF: begin
                cur_op    = CUR_HOME;
                state_nxt = S_CLEAR;
              end
              default: begin
                // character goes in at the old cursor, then step on
                if (printable) begin
                  cur_op    = CUR_STEP;
                  ram_we    = 1'b1;
                  ram_wdata = {color_r, in_char_code};
                end
              end
            endcase
          end
        end
      end
      S_MARK: begin
        // blank the cell under the new cursor
        ram_we    = 1'b1;
        state_nxt = S_IDLE;
      end
      S_READ: begin
        state_nxt = S_IDLE;
      end
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = {clr_color_r, CODE_W'(0)};
        if (clr_last) begin
          state_nxt = clr_ff_r ? S_MARK : S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer state and result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_addr_r   <= '0;
      clr_color_r  <= RESET_COLOR;
      clr_ff_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= (state_r == S_MARK) || (state_r == S_READ);
      if (state_r == S_CLEAR) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if (state_r == S_IDLE && accept) begin
        rd_ok_r     <= addr_ok;
        clr_addr_r  <= '0;
        clr_color_r <= color_r;
        clr_ff_r    <= 1'b1;
      end
      if (state_r == S_MARK) begin
        out_cursor_pos_r <= cur_ext[POS_W-1:0];
        out_cell_data_r  <= '0;
      end
      if (state_r == S_READ) begin
        out_cursor_pos_r <= cur_ext[POS_W-1:0];
        out_cell_data_r  <= rd_ok_r ? ram_rdata : '0;
      end
    end
  end

  // attribute register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r <= RESET_COLOR;
    end else if (cfg_we) begin
      color_r <= cfg_wdata;
    end
  end

  assign busy           = (state_r != S_IDLE);
  assign out_strobe     = out_strobe_r;
  assign out_cursor_pos = out_cursor_pos_r;
  assign out_cell_data  = out_cell_data_r;

  // an accepted word always occupies the sequencer for the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted word did not raise busy");
  // a result word only follows mark or read
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r == S_MARK || state_r == S_READ))
    else $error("result word without a finished command");
  // the read cycle never shares the RAM with a write
  a_read_no_wr: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ |-> !ram_we)
    else $error("RAM write during read");
  // a read beyond the screen returns zero
  a_read_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ && !rd_ok_r |=> out_cell_data == '0)
    else $error("out of range read returned data");

endmodule

[hdl/tcw_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[hdl/tcw_cursor.sv]
// Cursor unit: holds cursor position as row base plus column, applies moves.
// Depends on tcw_pkg (cur_op_t, TAB_STEP).
module tcw_cursor #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tcw_pkg::cur_op_t              op,
  output logic [$clog2(COLS*ROWS)-1:0]  cursor
);
  import tcw_pkg::*;

  localparam int CELLS = COLS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLS);

  logic [AW-1:0] cursor_r, cursor_nxt;
  logic [AW-1:0] rowbase_r, rowbase_nxt;
  logic [CW-1:0] col_r, col_nxt;

  logic [AW:0]   rb_plus;
  logic [AW-1:0] row_next;
  logic [AW-1:0] row_prev;
  logic [CW:0]   col_tab;
  logic [CW:0]   col_tab_wrap;

  // neighbouring rows, wrapping at the bottom of the screen
  assign rb_plus      = {1'b0, rowbase_r} + (AW+1)'(COLS);
  assign row_next     = (rb_plus == (AW+1)'(CELLS)) ? '0 : rb_plus[AW-1:0];
  assign row_prev     = rowbase_r - AW'(COLS);
  assign col_tab      = {1'b0, col_r} + (CW+1)'(TAB_STEP);
  assign col_tab_wrap = col_tab - (CW+1)'(COLS);

  // next position
  always_comb begin
    col_nxt     = col_r;
    rowbase_nxt = rowbase_r;
    unique case (op)
      CUR_STEP: begin
        if (col_r == CW'(COLS - 1)) begin
          col_nxt     = '0;
          rowbase_nxt = row_next;
        end else begin
          col_nxt = col_r + CW'(1);
        end
      end
      CUR_BACK: begin
        // stops at the first cell
        if (cursor_r != '0) begin
          if (col_r != '0) begin
            col_nxt = col_r - CW'(1);
          end else begin
            col_nxt     = CW'(COLS - 1);
            rowbase_nxt = row_prev;
          end
        end
      end
      CUR_TAB: begin
        if (col_tab >= (CW+1)'(COLS)) begin
          col_nxt     = col_tab_wrap[CW-1:0];
          rowbase_nxt = row_next;
        end else begin
          col_nxt = col_tab[CW-1:0];
        end
      end
      CUR_LF: begin
        col_nxt     = '0;
        rowbase_nxt = row_next;
      end
      CUR_CR: begin
        col_nxt = '0;
      end
      CUR_HOME: begin
        col_nxt     = '0;
        rowbase_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  assign cursor_nxt = rowbase_nxt + AW'(col_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r  <= '0;
      rowbase_r <= '0;
      col_r     <= '0;
    end else begin
      cursor_r  <= cursor_nxt;
      rowbase_r <= rowbase_nxt;
      col_r     <= col_nxt;
    end
  end

  assign cursor = cursor_r;

  // position stays on screen and consistent with its row/column split
  a_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r < AW'(CELLS - 1) || cursor_r == AW'(CELLS - 1))
    else $error("cursor off screen");
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= CW'(COLS - 1))
    else $error("column out of range");
  a_split: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r == rowbase_r + AW'(col_r))
    else $error("cursor differs from row base plus column");
  a_home: assert property (@(posedge clk) disable iff (!rst_n)
    op == CUR_HOME |=> cursor_r == '0)
    else $error("home did not reach first cell");

endmodule

[tb/text_console_char_writer_test.sv]
// Self-checking testbench for text_console_char_writer: directed and random
// put/read words, checked against a screen and cursor predictor kept here.
// Depends on tcw_pkg and the text_console_char_writer RTL.
`timescale 1ns / 1ps

module text_console_char_writer_test;
  import tcw_pkg::*;

  localparam int COLS  = 80;
  localparam int ROWS  = 25;
  localparam int CELLS = COLS * ROWS;

  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam int RANDOM_WORDS   = 1000;
  localparam int WATCHDOG_LIMIT = 12000;

  typedef struct {
    logic              cmd;
    logic [CODE_W-1:0] code;
    logic [POS_W-1:0]  addr;
  } console_word_t;

  typedef struct {
    logic [POS_W-1:0]  pos;
    logic [CELL_W-1:0] data;
  } console_result_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic               in_command;
  logic [CODE_W-1:0]  in_char_code;
  logic [POS_W-1:0]   in_cell_address;
  logic               out_strobe;
  logic [POS_W-1:0]   out_cursor_pos;
  logic [CELL_W-1:0]  out_cell_data;
  logic               cfg_we;
  logic [ATTR_W-1:0]  cfg_wdata;

  console_word_t   pending_words[$];
  console_result_t expected_results[$];
  console_word_t   next_word;

  // Screen model
  logic [CELL_W-1:0] screen_model[CELLS];
  int                cursor_model;
  logic [ATTR_W-1:0] colour_model;

  int sender_idle_pct;
  int counted_words;
  int error_count;
  int puts_seen, reads_seen, clears_seen, wraps_seen, results_seen;
  int quiet_cycles;

  text_console_char_writer #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_command(in_command),
    .in_char_code(in_char_code),
    .in_cell_address(in_cell_address),
    .out_strobe(out_strobe),
    .out_cursor_pos(out_cursor_pos),
    .out_cell_data(out_cell_data),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Work out the result of one accepted word and update the screen model
  task automatic apply_word(input console_word_t w);
    console_result_t r;
    int              c;
    int              old_c;
    logic [CELL_W-1:0] blank;
    blank = {colour_model, 8'h00};
    r.data = '0;
    c = cursor_model;
    old_c = c;
    if (w.cmd == CMD_PUT) begin
      puts_seen++;
      if (w.code >= PRINT_LO && w.code <= PRINT_HI) begin
        screen_model[c] = {colour_model, w.code};
        c = (c + 1) % CELLS;
      end else begin
        case (w.code)
          CH_BS: begin
            if (c > 0) c--;
            screen_model[c] = blank;
          end
          CH_TAB: c = (c + TAB_STEP) % CELLS;
          CH_LF:  c = ((c / COLS + 1) * COLS) % CELLS;
          CH_FF: begin
            for (int i = 0; i < CELLS; i++) screen_model[i] = blank;
            c = 0;
            clears_seen++;
          end
          CH_CR: c = c - c % COLS;
          default: ;
        endcase
      end
      if (c < old_c && w.code != CH_BS && w.code != CH_CR && w.code != CH_FF) wraps_seen++;
      // cursor mark
      screen_model[c] = blank;
      cursor_model = c;
    end else begin
      reads_seen++;
      if (w.addr < CELLS) r.data = screen_model[w.addr];
    end
    r.pos = cursor_model[POS_W-1:0];
    expected_results.push_back(r);
  endtask

  // Predictor: tracks config writes and accepted words
  always @(posedge clk) begin
    console_word_t w;
    if (!rst_n) begin
      colour_model = RESET_COLOR;
      cursor_model = 0;
      for (int i = 0; i < CELLS; i++) screen_model[i] = {RESET_COLOR, 8'h00};
    end else begin
      if (cfg_we) colour_model = cfg_wdata;
      if (start && !busy) begin
        w.cmd  = in_command;
        w.code = in_char_code;
        w.addr = in_cell_address;
        apply_word(w);
      end
    end
  end

  // Driver: presents queued words, idling at random
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (pending_words.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        next_word = pending_words.pop_front();
        start           <= 1'b1;
        in_command      <= next_word.cmd;
        in_char_code    <= next_word.code;
        in_cell_address <= next_word.addr;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobed word is checked against the oldest expectation
  always @(posedge clk) begin
    console_result_t e;
    if (rst_n && out_strobe) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("unexpected result word: cursor_pos %0d cell_data 0x%04h",
               out_cursor_pos, out_cell_data);
        error_count++;
      end else begin
        e = expected_results.pop_front();
        if (out_cursor_pos !== e.pos) begin
          $error("cursor_pos: expected %0d, got %0d", e.pos, out_cursor_pos);
          error_count++;
        end
        if (out_cell_data !== e.data) begin
          $error("cell_data: expected 0x%04h, got 0x%04h", e.data, out_cell_data);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_word(input logic cmd, input int code, input int addr);
    console_word_t w;
    w.cmd  = cmd;
    w.code = code[CODE_W-1:0];
    w.addr = addr[POS_W-1:0];
    pending_words.push_back(w);
    // ignored codes do not count towards the random total
    if (cmd == CMD_READ || (code >= PRINT_LO && code <= PRINT_HI) || code == CH_BS ||
        code == CH_TAB || code == CH_LF || code == CH_FF || code == CH_CR)
      counted_words++;
  endtask

  task automatic put_code(input int code);
    queue_word(CMD_PUT, code, $urandom_range(0, 2047));
  endtask

  // One random burst: mostly well-formed text, control runs and reads, some noise
  task automatic queue_burst();
    int kind;
    int n;
    int a;
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      n = $urandom_range(1, 24);
      repeat (n) put_code($urandom_range(PRINT_LO, PRINT_HI));
      n = $urandom_range(0, 3);
      if (n == 0) begin
        put_code(CH_CR);
        put_code(CH_LF);
      end else if (n == 1) begin
        put_code(CH_LF);
      end
    end else if (kind < 50) begin
      repeat ($urandom_range(5, 30)) put_code(CH_LF);
    end else if (kind < 58) begin
      repeat ($urandom_range(1, 12)) put_code(CH_TAB);
    end else if (kind < 66) begin
      repeat ($urandom_range(1, 12)) put_code(CH_BS);
    end else if (kind < 86) begin
      repeat ($urandom_range(1, 6)) begin
        n = $urandom_range(0, 9);
        if (n == 0) a = $urandom_range(CELLS, 2047);
        else if (n < 6) a = $urandom_range(0, 255);
        else a = $urandom_range(0, 2047);
        queue_word(CMD_READ, $urandom_range(0, 255), a);
      end
    end else if (kind < 96) begin
      repeat ($urandom_range(1, 4))
        queue_word(1'($urandom_range(0, 1)), $urandom_range(0, 255),
                   $urandom_range(0, 2047));
    end else if (kind < 98) begin
      put_code(CH_FF);
    end else begin
      n = $urandom_range(0, 3);
      put_code(n == 0 ? CH_BS : n == 1 ? CH_TAB : n == 2 ? CH_LF : CH_CR);
    end
  endtask

  // Wait until every queued word has been taken and answered
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_words.size() != 0 || start || busy || expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_colour(input logic [ATTR_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Stimulus and end of run
  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_command      = CMD_PUT;
    in_char_code    = '0;
    in_cell_address = '0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    quiet_cycles    = 0;
    error_count     = 0;
    sender_idle_pct = 35;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset screen, field extremes, every control code
    queue_word(CMD_READ, 0, 0);
    queue_word(CMD_READ, 255, CELLS - 1);
    queue_word(CMD_READ, 0, CELLS);
    queue_word(CMD_READ, 0, 2047);
    queue_word(CMD_PUT, "A", 0);
    queue_word(CMD_PUT, PRINT_LO, 2047);
    queue_word(CMD_PUT, PRINT_HI, 0);
    queue_word(CMD_PUT, 31, 0);
    queue_word(CMD_PUT, 127, 0);
    queue_word(CMD_PUT, 255, 0);
    queue_word(CMD_PUT, 0, 0);
    queue_word(CMD_PUT, 128, 0);
    queue_word(CMD_READ, 0, 0);
    repeat (4) queue_word(CMD_PUT, CH_BS, 0);  // last one saturates at zero
    queue_word(CMD_PUT, CH_TAB, 0);
    queue_word(CMD_PUT, "z", 0);
    queue_word(CMD_PUT, CH_LF, 0);
    queue_word(CMD_PUT, "q", 0);
    queue_word(CMD_PUT, CH_CR, 0);
    queue_word(CMD_READ, 0, 8);
    queue_word(CMD_PUT, CH_FF, 0);
    queue_word(CMD_READ, 0, 8);
    wait_drained();

    // Random: three parts, each with its own colour and sender idling
    for (int part = 0; part < 3; part++) begin
      case (part)
        0: write_colour(8'h00);
        1: write_colour(8'hFF);
        default: write_colour(8'($urandom_range(1, 254)));
      endcase
      sender_idle_pct = (part == 0) ? 35 : (part == 1) ? 52 : 0;
      counted_words = 0;
      while (counted_words < RANDOM_WORDS / 3) queue_burst();
      wait_drained();
    end

    repeat (8) @(posedge clk);
    $display("Covered %0d puts and %0d reads (%0d results), %0d screen clears,",
             puts_seen, reads_seen, results_seen, clears_seen);
    $display("%0d cursor wraps, colours reset/0x00/0xFF/random.", wraps_seen);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[files.f]
hdl/tcw_pkg.sv
hdl/tcw_ram.sv
hdl/tcw_cursor.sv
hdl/text_console_char_writer.sv
tb/text_console_char_writer_test.sv
